// ===== sv/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// Types and constants shared by the 1-wire bus master files.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  // Number of bus lines that really exist behind the fixed four-bit ports.
  localparam int unsigned BUS_COUNT = 4;

  localparam int unsigned CFG_W = 10;

  localparam logic [CFG_W-1:0] RESET_LOW_DEF      = 10'd750;
  localparam logic [CFG_W-1:0] RESET_RECOVERY_DEF = 10'd15;
  localparam logic [CFG_W-1:0] PRES_TIMEOUT_DEF   = 10'd200;
  localparam logic [CFG_W-1:0] PRES_END_DEF       = 10'd240;
  localparam logic [CFG_W-1:0] SHORT_LOW_DEF      = 10'd2;
  localparam logic [CFG_W-1:0] SLOT_LONG_DEF      = 10'd61;
  localparam logic [CFG_W-1:0] READ_SAMPLE_DEF    = 10'd3;
  localparam logic [CFG_W-1:0] READ_RECOVERY_DEF  = 10'd56;

  typedef enum logic [2:0] {
    REG_RESET_LOW      = 3'd0,
    REG_RESET_RECOVERY = 3'd1,
    REG_PRES_TIMEOUT   = 3'd2,
    REG_PRES_END       = 3'd3,
    REG_SHORT_LOW      = 3'd4,
    REG_SLOT_LONG      = 3'd5,
    REG_READ_SAMPLE    = 3'd6,
    REG_READ_RECOVERY  = 3'd7
  } owbm_reg_e;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_RESET = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } owbm_func_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REC   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_END  = 4'd4,
    PH_WR_A      = 4'd5,
    PH_WR_B      = 4'd6,
    PH_RD_LOW    = 4'd7,
    PH_RD_WAIT   = 4'd8,
    PH_RD_REC    = 4'd9
  } owbm_phase_e;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_time;
    logic [CFG_W-1:0] reset_recovery_time;
    logic [CFG_W-1:0] presence_timeout;
    logic [CFG_W-1:0] presence_end_timeout;
    logic [CFG_W-1:0] short_low_time;
    logic [CFG_W-1:0] slot_long_time;
    logic [CFG_W-1:0] read_sample_delay;
    logic [CFG_W-1:0] read_recovery_time;
  } owbm_cfg_t;

endpackage

`default_nettype wire

// ===== sv/owbm_req_if.sv =====
// ----------------------------------------------------------------------------
// owbm_req_if
// Request channel of the 1-wire bus master: ticks and commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface owbm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] bus_select;
  logic [7:0] data_byte;
  logic [3:0] line_levels;

  modport source (output valid, output func, output bus_select, output data_byte,
                  output line_levels, input ready);
  modport sink   (input valid, input func, input bus_select, input data_byte,
                  input line_levels, output ready);
endinterface

`default_nettype wire

// ===== sv/owbm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// owbm_rsp_if
// Result channel of the 1-wire bus master: one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface owbm_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] drive_low_mask;
  logic       busy_res;
  logic       done_res;
  logic       no_presence;
  logic [7:0] read_data;
  logic       rejected;

  modport source (output valid, output drive_low_mask, output busy_res, output done_res,
                  output no_presence, output read_data, output rejected, input ready);
  modport sink   (input valid, input drive_low_mask, input busy_res, input done_res,
                  input no_presence, input read_data, input rejected, output ready);
endinterface

`default_nettype wire

// ===== sv/owbm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// owbm_cfg_regs
// Slot timing registers of the 1-wire bus master, written through a plain
// write port and loaded with the standard timings at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [2:0]                 cfg_idx_i,
  input  wire logic [owbm_pkg::CFG_W-1:0] cfg_wdata_i,
  output owbm_pkg::owbm_cfg_t             cfg_o
);

  owbm_pkg::owbm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (owbm_pkg::owbm_reg_e'(cfg_idx_i))
        owbm_pkg::REG_RESET_LOW:      cfg_d.reset_low_time       = cfg_wdata_i;
        owbm_pkg::REG_RESET_RECOVERY: cfg_d.reset_recovery_time  = cfg_wdata_i;
        owbm_pkg::REG_PRES_TIMEOUT:   cfg_d.presence_timeout     = cfg_wdata_i;
        owbm_pkg::REG_PRES_END:       cfg_d.presence_end_timeout = cfg_wdata_i;
        owbm_pkg::REG_SHORT_LOW:      cfg_d.short_low_time       = cfg_wdata_i;
        owbm_pkg::REG_SLOT_LONG:      cfg_d.slot_long_time       = cfg_wdata_i;
        owbm_pkg::REG_READ_SAMPLE:    cfg_d.read_sample_delay    = cfg_wdata_i;
        owbm_pkg::REG_READ_RECOVERY:  cfg_d.read_recovery_time   = cfg_wdata_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time       <= owbm_pkg::RESET_LOW_DEF;
      cfg_q.reset_recovery_time  <= owbm_pkg::RESET_RECOVERY_DEF;
      cfg_q.presence_timeout     <= owbm_pkg::PRES_TIMEOUT_DEF;
      cfg_q.presence_end_timeout <= owbm_pkg::PRES_END_DEF;
      cfg_q.short_low_time       <= owbm_pkg::SHORT_LOW_DEF;
      cfg_q.slot_long_time       <= owbm_pkg::SLOT_LONG_DEF;
      cfg_q.read_sample_delay    <= owbm_pkg::READ_SAMPLE_DEF;
      cfg_q.read_recovery_time   <= owbm_pkg::READ_RECOVERY_DEF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-wire bus master with one shared timing engine for several bus lines.
// ----------------------------------------------------------------------------
// Usage: every request on req_i is either a one-microsecond tick or a
// command (bus reset with presence detect, write byte, read byte) for the
// bus picked by bus_select. Each request carries the sampled line levels.
// A command that arrives while an operation runs is answered with rejected
// and changes nothing. Each request yields exactly one result on rsp_o,
// which tells which line to pull low, whether the engine is busy, and on
// the finishing request done, the read byte and the presence status.
// The result is valid in the cycle after the request is taken. Throughput
// is one request per cycle, set by the single state register stage
// feeding the result register. It holds a result while rsp_o is stalled;
// req_i.ready is low only while a result waits and is not taken in that
// cycle. The user must write timing registers on the cfg port only while
// the engine is idle; the block does not enforce it. Reset returns the
// engine to idle, releases all lines and loads the standard slot timings.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [2:0]                 cfg_idx_i,
  input  wire logic [owbm_pkg::CFG_W-1:0] cfg_wdata_i,
  owbm_req_if.sink                        req_i,
  owbm_rsp_if.source                      rsp_o
);

  owbm_pkg::owbm_cfg_t cfg;

  owbm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Engine state
  owbm_pkg::owbm_phase_e        phase_q, phase_d;
  logic [owbm_pkg::CFG_W-1:0]   tick_count_q, tick_count_d;
  logic [2:0]                   bit_index_q, bit_index_d;
  logic [7:0]                   shift_byte_q, shift_byte_d;
  logic [1:0]                   active_bus_q, active_bus_d;
  logic                         pres_failed_q, pres_failed_d;

  // Result register
  logic       out_valid_q;
  logic [3:0] drive_mask_q, drive_mask_d;
  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [7:0] rdata_q, rdata_d;
  logic       reject_q, reject_d;

  logic                       accept;
  logic [owbm_pkg::CFG_W-1:0] len_sel;
  logic [owbm_pkg::CFG_W-1:0] tick_inc;
  logic                       expired;
  logic [owbm_pkg::CFG_W-1:0] cnt_adv;
  logic                       line_high;
  logic                       bus_ok_d;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // A bus beyond the populated ones reads high and is never pulled.
  assign line_high = (32'(active_bus_q) < owbm_pkg::BUS_COUNT)
                     ? req_i.line_levels[active_bus_q] : 1'b1;

  // One shared phase counter; a phase of length L ends on its L-th tick,
  // and a zero length behaves as one tick.
  assign tick_inc = tick_count_q + 10'd1;
  assign expired  = (tick_inc >= len_sel);
  assign cnt_adv  = expired ? '0 : tick_inc;

  // Next state
  always_comb begin
    phase_d       = phase_q;
    tick_count_d  = tick_count_q;
    bit_index_d   = bit_index_q;
    shift_byte_d  = shift_byte_q;
    active_bus_d  = active_bus_q;
    pres_failed_d = pres_failed_q;
    done_d        = 1'b0;
    rdata_d       = '0;
    reject_d      = 1'b0;

    unique case (phase_q)
      owbm_pkg::PH_RST_LOW:   len_sel = cfg.reset_low_time;
      owbm_pkg::PH_RST_REC:   len_sel = cfg.reset_recovery_time;
      owbm_pkg::PH_PRES_WAIT: len_sel = cfg.presence_timeout;
      owbm_pkg::PH_PRES_END:  len_sel = cfg.presence_end_timeout;
      owbm_pkg::PH_WR_A:      len_sel = shift_byte_q[0] ? cfg.short_low_time
                                                        : cfg.slot_long_time;
      owbm_pkg::PH_WR_B:      len_sel = shift_byte_q[0] ? cfg.slot_long_time
                                                        : cfg.short_low_time;
      owbm_pkg::PH_RD_LOW:    len_sel = cfg.short_low_time;
      owbm_pkg::PH_RD_WAIT:   len_sel = cfg.read_sample_delay;
      owbm_pkg::PH_RD_REC:    len_sel = cfg.read_recovery_time;
      default:                len_sel = cfg.short_low_time;
    endcase

    if (owbm_pkg::owbm_func_e'(req_i.func) != owbm_pkg::FUNC_TICK) begin
      if (phase_q != owbm_pkg::PH_IDLE) begin
        reject_d = 1'b1;
      end else begin
        active_bus_d = req_i.bus_select;
        tick_count_d = '0;
        bit_index_d  = '0;
        priority if (owbm_pkg::owbm_func_e'(req_i.func) == owbm_pkg::FUNC_RESET) begin
          pres_failed_d = 1'b0;
          phase_d       = owbm_pkg::PH_RST_LOW;
        end else if (owbm_pkg::owbm_func_e'(req_i.func) == owbm_pkg::FUNC_WRITE) begin
          shift_byte_d = req_i.data_byte;
          phase_d      = owbm_pkg::PH_WR_A;
        end else begin
          shift_byte_d = '0;
          phase_d      = owbm_pkg::PH_RD_LOW;
        end
      end
    end else begin
      unique case (phase_q)
        owbm_pkg::PH_IDLE: begin
          phase_d = owbm_pkg::PH_IDLE;
        end
        owbm_pkg::PH_RST_LOW: begin
          tick_count_d = cnt_adv;
          if (expired) phase_d = owbm_pkg::PH_RST_REC;
        end
        owbm_pkg::PH_RST_REC: begin
          tick_count_d = cnt_adv;
          if (expired) phase_d = owbm_pkg::PH_PRES_WAIT;
        end
        owbm_pkg::PH_PRES_WAIT: begin
          if (!line_high) begin
            tick_count_d = '0;
            phase_d      = owbm_pkg::PH_PRES_END;
          end else begin
            tick_count_d = cnt_adv;
            if (expired) begin
              pres_failed_d = 1'b1;
              phase_d       = owbm_pkg::PH_IDLE;
              done_d        = 1'b1;
            end
          end
        end
        owbm_pkg::PH_PRES_END: begin
          if (line_high) begin
            tick_count_d = '0;
            phase_d      = owbm_pkg::PH_IDLE;
            done_d       = 1'b1;
          end else begin
            tick_count_d = cnt_adv;
            if (expired) begin
              pres_failed_d = 1'b1;
              phase_d       = owbm_pkg::PH_IDLE;
              done_d        = 1'b1;
            end
          end
        end
        owbm_pkg::PH_WR_A: begin
          tick_count_d = cnt_adv;
          if (expired) phase_d = owbm_pkg::PH_WR_B;
        end
        owbm_pkg::PH_WR_B: begin
          tick_count_d = cnt_adv;
          if (expired) begin
            shift_byte_d = {1'b0, shift_byte_q[7:1]};
            if (bit_index_q == 3'd7) begin
              bit_index_d = '0;
              phase_d     = owbm_pkg::PH_IDLE;
              done_d      = 1'b1;
            end else begin
              bit_index_d = bit_index_q + 3'd1;
              phase_d     = owbm_pkg::PH_WR_A;
            end
          end
        end
        owbm_pkg::PH_RD_LOW: begin
          tick_count_d = cnt_adv;
          if (expired) phase_d = owbm_pkg::PH_RD_WAIT;
        end
        owbm_pkg::PH_RD_WAIT: begin
          tick_count_d = cnt_adv;
          if (expired) begin
            shift_byte_d = {line_high, shift_byte_q[7:1]};
            phase_d      = owbm_pkg::PH_RD_REC;
          end
        end
        owbm_pkg::PH_RD_REC: begin
          tick_count_d = cnt_adv;
          if (expired) begin
            if (bit_index_q == 3'd7) begin
              bit_index_d = '0;
              phase_d     = owbm_pkg::PH_IDLE;
              done_d      = 1'b1;
              rdata_d     = shift_byte_q;
            end else begin
              bit_index_d = bit_index_q + 3'd1;
              phase_d     = owbm_pkg::PH_RD_LOW;
            end
          end
        end
        default: begin
          phase_d = owbm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Result fields, taken from the state after this request.
  assign bus_ok_d = (32'(active_bus_d) < owbm_pkg::BUS_COUNT);

  always_comb begin
    drive_mask_d = '0;
    if (bus_ok_d && (phase_d == owbm_pkg::PH_RST_LOW || phase_d == owbm_pkg::PH_WR_A ||
                     phase_d == owbm_pkg::PH_RD_LOW)) begin
      drive_mask_d = 4'b0001 << active_bus_d;
    end
    busy_d = (phase_d != owbm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= owbm_pkg::PH_IDLE;
      tick_count_q  <= '0;
      bit_index_q   <= '0;
      shift_byte_q  <= '0;
      active_bus_q  <= '0;
      pres_failed_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        phase_q       <= phase_d;
        tick_count_q  <= tick_count_d;
        bit_index_q   <= bit_index_d;
        shift_byte_q  <= shift_byte_d;
        active_bus_q  <= active_bus_d;
        pres_failed_q <= pres_failed_d;
        out_valid_q   <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drive_mask_q <= drive_mask_d;
      busy_q       <= busy_d;
      done_q       <= done_d;
      rdata_q      <= rdata_d;
      reject_q     <= reject_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.drive_low_mask = drive_mask_q;
  assign rsp_o.busy_res       = busy_q;
  assign rsp_o.done_res       = done_q;
  assign rsp_o.no_presence    = pres_failed_q;
  assign rsp_o.read_data      = rdata_q;
  assign rsp_o.rejected       = reject_q;

`ifndef NO_ASSERTIONS
  // A rejected command can only arrive while an operation keeps running.
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && reject_q) |-> busy_q)
    else $error("rejected result while engine idle");

  // Finishing an operation always leaves the engine idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (!busy_q && !reject_q))
    else $error("done result while engine still busy");

  // At most one line is pulled low, and only during an operation.
  a_one_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($onehot0(drive_mask_q) && (drive_mask_q == 4'b0000 || busy_q)))
    else $error("bad drive mask");

  // Read data is only presented with a finished operation.
  a_rdata_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rdata_q != 8'h00) |-> done_q)
    else $error("read data without done");

  // The phase counter is always cleared when the engine returns to idle.
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == owbm_pkg::PH_IDLE) |-> (tick_count_q == '0 && bit_index_q == 3'd0))
    else $error("idle with stale counters");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the 1-wire bus master. A queue of pending
// requests feeds a bursty driver, a monitor with a stalling ready checks
// every result against a cycle-free model of the timing engine, and the
// timing registers are reprogrammed between idle phases.
// ----------------------------------------------------------------------------

module tb_top;
  import owbm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned TOTAL_ITEMS = 1100;
  localparam int unsigned PHASE_ITEMS = 60;
  localparam int LV_LOW  = 0;
  localparam int LV_HIGH = 1;
  localparam int LV_ANY  = 2;

  typedef struct packed {
    owbm_func_e func;
    logic [1:0] bus;
    logic [7:0] data;
    logic [3:0] levels;
  } req_t;

  typedef struct packed {
    logic [3:0] drive_low_mask;
    logic       busy_res;
    logic       done_res;
    logic       no_presence;
    logic [7:0] read_data;
    logic       rejected;
  } rsp_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [2:0]       cfg_idx   = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             req_valid = 1'b0;
  logic [1:0]       req_func  = '0;
  logic [1:0]       req_bus   = '0;
  logic [7:0]       req_data  = '0;
  logic [3:0]       req_lv    = '0;
  logic             rsp_ready = 1'b0;

  owbm_req_if req_if ();
  owbm_rsp_if rsp_if ();

  assign req_if.valid       = req_valid;
  assign req_if.func        = req_func;
  assign req_if.bus_select  = req_bus;
  assign req_if.data_byte   = req_data;
  assign req_if.line_levels = req_lv;
  assign rsp_if.ready       = rsp_ready;

  one_wire_bus_master dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   issued     = 0;
  int   accepted   = 0;
  int   mismatches = 0;
  int unsigned cycle_cnt = 0;

  // Timing values the stimulus is built for; mirrored into the block.
  logic [CFG_W-1:0] gen_cfg [8];

  // Model of the timing engine.
  logic [CFG_W-1:0] eng_cfg [8];
  owbm_phase_e      eng_phase;
  logic [9:0]       eng_ticks;
  logic [2:0]       eng_bit;
  logic [7:0]       eng_shift;
  logic [1:0]       eng_bus;
  logic             eng_pres_fail;

  // --------------------------------------------------------------------------
  // Engine model
  // --------------------------------------------------------------------------
  function automatic logic bus_present();
    return int'(eng_bus) < int'(BUS_COUNT);
  endfunction

  function automatic logic line_is_high(logic [3:0] lv);
    if (!bus_present()) return 1'b1;
    return lv[eng_bus];
  endfunction

  // Counts one tick of the current slot; a length of zero ends after one tick.
  function automatic logic slot_over(logic [CFG_W-1:0] len);
    eng_ticks = eng_ticks + 10'd1;
    if (eng_ticks >= len) begin
      eng_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rsp_t step_engine(req_t it);
    rsp_t r;
    logic bitv;
    r = '0;
    bitv = eng_shift[0];
    if (it.func != FUNC_TICK) begin
      if (eng_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        eng_bus   = it.bus;
        eng_ticks = '0;
        eng_bit   = '0;
        case (it.func)
          FUNC_RESET: begin
            eng_pres_fail = 1'b0;
            eng_phase     = PH_RST_LOW;
          end
          FUNC_WRITE: begin
            eng_shift = it.data;
            eng_phase = PH_WR_A;
          end
          default: begin
            eng_shift = '0;
            eng_phase = PH_RD_LOW;
          end
        endcase
      end
    end else begin
      case (eng_phase)
        PH_RST_LOW: begin
          if (slot_over(eng_cfg[REG_RESET_LOW])) eng_phase = PH_RST_REC;
        end
        PH_RST_REC: begin
          if (slot_over(eng_cfg[REG_RESET_RECOVERY])) eng_phase = PH_PRES_WAIT;
        end
        PH_PRES_WAIT: begin
          if (!line_is_high(it.levels)) begin
            eng_ticks = '0;
            eng_phase = PH_PRES_END;
          end else if (slot_over(eng_cfg[REG_PRES_TIMEOUT])) begin
            eng_pres_fail = 1'b1;
            eng_phase     = PH_IDLE;
            r.done_res    = 1'b1;
          end
        end
        PH_PRES_END: begin
          if (line_is_high(it.levels)) begin
            eng_ticks  = '0;
            eng_phase  = PH_IDLE;
            r.done_res = 1'b1;
          end else if (slot_over(eng_cfg[REG_PRES_END])) begin
            eng_pres_fail = 1'b1;
            eng_phase     = PH_IDLE;
            r.done_res    = 1'b1;
          end
        end
        PH_WR_A: begin
          if (slot_over(bitv ? eng_cfg[REG_SHORT_LOW] : eng_cfg[REG_SLOT_LONG]))
            eng_phase = PH_WR_B;
        end
        PH_WR_B: begin
          if (slot_over(bitv ? eng_cfg[REG_SLOT_LONG] : eng_cfg[REG_SHORT_LOW])) begin
            eng_shift = eng_shift >> 1;
            if (eng_bit == 3'd7) begin
              eng_bit    = '0;
              eng_phase  = PH_IDLE;
              r.done_res = 1'b1;
            end else begin
              eng_bit   = eng_bit + 3'd1;
              eng_phase = PH_WR_A;
            end
          end
        end
        PH_RD_LOW: begin
          if (slot_over(eng_cfg[REG_SHORT_LOW])) eng_phase = PH_RD_WAIT;
        end
        PH_RD_WAIT: begin
          if (slot_over(eng_cfg[REG_READ_SAMPLE])) begin
            eng_shift = {line_is_high(it.levels), eng_shift[7:1]};
            eng_phase = PH_RD_REC;
          end
        end
        PH_RD_REC: begin
          if (slot_over(eng_cfg[REG_READ_RECOVERY])) begin
            if (eng_bit == 3'd7) begin
              eng_bit     = '0;
              eng_phase   = PH_IDLE;
              r.done_res  = 1'b1;
              r.read_data = eng_shift;
            end else begin
              eng_bit   = eng_bit + 3'd1;
              eng_phase = PH_RD_LOW;
            end
          end
        end
        default: begin
          eng_phase = PH_IDLE;
        end
      endcase
    end
    if ((eng_phase == PH_RST_LOW || eng_phase == PH_WR_A || eng_phase == PH_RD_LOW)
        && bus_present())
      r.drive_low_mask = 4'b0001 << eng_bus;
    r.busy_res    = (eng_phase != PH_IDLE);
    r.no_presence = eng_pres_fail;
    return r;
  endfunction

  // The model follows register writes and accepted requests edge by edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      eng_cfg[REG_RESET_LOW]      = RESET_LOW_DEF;
      eng_cfg[REG_RESET_RECOVERY] = RESET_RECOVERY_DEF;
      eng_cfg[REG_PRES_TIMEOUT]   = PRES_TIMEOUT_DEF;
      eng_cfg[REG_PRES_END]       = PRES_END_DEF;
      eng_cfg[REG_SHORT_LOW]      = SHORT_LOW_DEF;
      eng_cfg[REG_SLOT_LONG]      = SLOT_LONG_DEF;
      eng_cfg[REG_READ_SAMPLE]    = READ_SAMPLE_DEF;
      eng_cfg[REG_READ_RECOVERY]  = READ_RECOVERY_DEF;
      eng_phase     = PH_IDLE;
      eng_ticks     = '0;
      eng_bit       = '0;
      eng_shift     = '0;
      eng_bus       = '0;
      eng_pres_fail = 1'b0;
    end else begin
      if (cfg_we) eng_cfg[cfg_idx] = cfg_wdata;
      if (req_valid && req_if.ready) begin
        expected_rsps.push_back(step_engine('{owbm_func_e'(req_func), req_bus, req_data,
                                              req_lv}));
        accepted <= accepted + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps
  // --------------------------------------------------------------------------
  int   burst_left = 1;
  int   gap_left   = 0;
  req_t drv_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_if.ready) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        drv_item = pending_reqs.pop_front();
        req_valid <= 1'b1;
        req_func  <= drv_item.func;
        req_bus   <= drv_item.bus;
        req_data  <= drv_item.data;
        req_lv    <= drv_item.levels;
        if (burst_left <= 1) begin
          if ($urandom_range(5) == 0) begin
            burst_left <= $urandom_range(100, 300);
            gap_left   <= 0;
          end else begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= $urandom_range(0, 6);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: stall pattern, long hold-offs, and the checker
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned stall_mode = 0;
  int unsigned pat_cnt = 0;
  bit          pressure_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (!pressure_done && accepted > 400) begin
      // Long hold-off while the driver keeps offering, so the input backs up.
      pressure_done <= 1'b1;
      hold_left     <= 250;
      rsp_ready     <= 1'b0;
    end else if ($urandom_range(1999) == 0) begin
      hold_left <= $urandom_range(100, 300);
      rsp_ready <= 1'b0;
    end else begin
      pat_cnt <= pat_cnt + 1;
      if (mode_left == 0) begin
        mode_left  <= $urandom_range(40, 300);
        stall_mode <= $urandom_range(0, 3);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= 1'($urandom_range(1));
        2: rsp_ready <= ($urandom_range(3) == 0);
        default: rsp_ready <= (pat_cnt % 3 == 0);
      endcase
    end
  end

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  rsp_t mon_want;

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, actual mask 0x%0h",
                 $time, rsp_if.drive_low_mask);
        mismatches++;
      end else begin
        mon_want = expected_rsps.pop_front();
        check_field("drive_low_mask", mon_want.drive_low_mask, rsp_if.drive_low_mask);
        check_field("busy_res", mon_want.busy_res, rsp_if.busy_res);
        check_field("done_res", mon_want.done_res, rsp_if.done_res);
        check_field("no_presence", mon_want.no_presence, rsp_if.no_presence);
        check_field("read_data", mon_want.read_data, rsp_if.read_data);
        check_field("rejected", mon_want.rejected, rsp_if.rejected);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_rsps.size());
      $display("FAIL one_wire_bus_master");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic int unsigned len1(logic [CFG_W-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic logic [3:0] lv_for(logic [1:0] bus, int mode);
    logic [3:0] v;
    v = 4'($urandom_range(15));
    if (mode == LV_LOW) v[bus] = 1'b0;
    else if (mode == LV_HIGH) v[bus] = 1'b1;
    return v;
  endfunction

  task automatic add_item(owbm_func_e f, logic [1:0] bus, logic [7:0] data, logic [3:0] lv);
    pending_reqs.push_back('{f, bus, data, lv});
    issued++;
  endtask

  task automatic add_ticks(int unsigned n, logic [1:0] bus, int mode);
    for (int unsigned i = 0; i < n; i++)
      add_item(FUNC_TICK, 2'($urandom_range(3)), 8'($urandom_range(255)), lv_for(bus, mode));
  endtask

  // A command of any kind with random content.
  task automatic add_stray();
    add_item(owbm_func_e'($urandom_range(1, 3)), 2'($urandom_range(3)),
             8'($urandom_range(255)), 4'($urandom_range(15)));
  endtask

  task automatic gen_reset(logic [1:0] bus, int unsigned wait_hi, int unsigned hold_lo,
                           bit busy_cmd);
    add_item(FUNC_RESET, bus, 8'($urandom_range(255)), lv_for(bus, LV_ANY));
    if (busy_cmd) add_stray();
    add_ticks(len1(gen_cfg[REG_RESET_LOW]) + len1(gen_cfg[REG_RESET_RECOVERY]), bus, LV_ANY);
    add_ticks(wait_hi, bus, LV_HIGH);
    add_ticks(hold_lo, bus, LV_LOW);
    add_ticks(1, bus, LV_HIGH);
  endtask

  task automatic gen_write(logic [1:0] bus, logic [7:0] data, bit busy_cmd);
    add_item(FUNC_WRITE, bus, data, lv_for(bus, LV_ANY));
    if (busy_cmd) add_stray();
    for (int i = 0; i < 8; i++)
      add_ticks(len1(gen_cfg[REG_SHORT_LOW]) + len1(gen_cfg[REG_SLOT_LONG]), bus, LV_ANY);
  endtask

  task automatic gen_read(logic [1:0] bus, logic [7:0] data, bit busy_cmd);
    add_item(FUNC_READ, bus, 8'($urandom_range(255)), lv_for(bus, LV_ANY));
    if (busy_cmd) add_stray();
    for (int i = 0; i < 8; i++) begin
      add_ticks(len1(gen_cfg[REG_SHORT_LOW]), bus, LV_ANY);
      add_ticks(len1(gen_cfg[REG_READ_SAMPLE]), bus, data[i] ? LV_HIGH : LV_LOW);
      add_ticks(len1(gen_cfg[REG_READ_RECOVERY]), bus, LV_ANY);
    end
  endtask

  // Waits for all results, then ticks with released lines until the engine is idle.
  task automatic settle();
    bit idle_now;
    idle_now = 1'b0;
    while (!idle_now) begin
      while (!(accepted == issued && expected_rsps.size() == 0)) @(posedge clk);
      if (eng_phase == PH_IDLE) idle_now = 1'b1;
      else add_ticks(40, eng_bus, LV_HIGH);
    end
  endtask

  task automatic program_timing();
    for (int i = 0; i <= int'(REG_READ_RECOVERY); i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= 3'(i);
      cfg_wdata <= gen_cfg[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all_timing(logic [CFG_W-1:0] v);
    for (int i = 0; i <= int'(REG_READ_RECOVERY); i++) gen_cfg[i] = v;
  endtask

  int phase_start;
  int op;

  initial begin
    gen_cfg[REG_RESET_LOW]      = RESET_LOW_DEF;
    gen_cfg[REG_RESET_RECOVERY] = RESET_RECOVERY_DEF;
    gen_cfg[REG_PRES_TIMEOUT]   = PRES_TIMEOUT_DEF;
    gen_cfg[REG_PRES_END]       = PRES_END_DEF;
    gen_cfg[REG_SHORT_LOW]      = SHORT_LOW_DEF;
    gen_cfg[REG_SLOT_LONG]      = SLOT_LONG_DEF;
    gen_cfg[REG_READ_SAMPLE]    = READ_SAMPLE_DEF;
    gen_cfg[REG_READ_RECOVERY]  = READ_RECOVERY_DEF;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timings: a tick while idle, then a bus reset that sees a command
    // arrive while busy.
    add_ticks(1, 2'd0, LV_ANY);
    gen_reset(2'd0, 5, 10, 1'b1);
    settle();

    // Minimum lengths: both byte extremes, and both presence timeouts.
    set_all_timing(10'd1);
    program_timing();
    gen_write(2'd1, 8'h00, 1'b0);
    gen_write(2'd2, 8'hFF, 1'b1);
    gen_read(2'd3, 8'hFF, 1'b0);
    gen_read(2'd0, 8'h00, 1'b1);
    gen_reset(2'd2, 2, 1, 1'b0);
    gen_reset(2'd3, 0, 2, 1'b0);
    settle();

    // Zero-length registers run as one-tick slots.
    set_all_timing(10'd0);
    program_timing();
    gen_write(2'd0, 8'hA5, 1'b0);
    gen_read(2'd1, 8'h3C, 1'b0);
    gen_reset(2'd2, 0, 1, 1'b0);
    settle();

    while (issued < TOTAL_ITEMS) begin
      for (int i = 0; i <= int'(REG_READ_RECOVERY); i++)
        gen_cfg[i] = ($urandom_range(7) == 0) ? 10'($urandom_range(7, 30))
                                              : 10'($urandom_range(1, 6));
      program_timing();
      phase_start = issued;
      while (issued - phase_start < PHASE_ITEMS) begin
        op = $urandom_range(0, 9);
        if (op <= 2)
          gen_reset(2'($urandom_range(3)), $urandom_range(0, len1(gen_cfg[REG_PRES_TIMEOUT])),
                    $urandom_range(1, len1(gen_cfg[REG_PRES_END])), $urandom_range(7) == 0);
        else if (op <= 5)
          gen_write(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom_range(7) == 0);
        else if (op <= 8)
          gen_read(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom_range(7) == 0);
        else
          repeat ($urandom_range(1, 3)) add_stray();
        add_ticks($urandom_range(0, 2), 2'($urandom_range(3)), LV_ANY);
      end
      settle();
    end

    while (!(accepted == issued && expected_rsps.size() == 0)) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0", $time,
               expected_rsps.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS one_wire_bus_master");
    end else begin
      $display("FAIL one_wire_bus_master");
    end
    $finish;
  end

endmodule
